@@ rtl/cell_voltage_fault_monitor_assert.svh @@
// ----------------------------------------------------------------------------
// Cell voltage fault monitor assertion macros
// Shorthand for the concurrent checks on the monitor's ports.
// ----------------------------------------------------------------------------
`ifndef CELL_VOLTAGE_FAULT_MONITOR_ASSERT_SVH
`define CELL_VOLTAGE_FAULT_MONITOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CVFM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define CVFM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// holds in the cycle after reset is seen
`define CVFM_ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cvfm_pkg.sv @@
// ----------------------------------------------------------------------------
// Cell voltage fault monitor package
// Field widths, register indices, reset values and shared types.
// ----------------------------------------------------------------------------
package cvfm_pkg;

   localparam int CELL_W     = 16;
   localparam int PACK_W     = 24;
   localparam int SOC_W      = 10;
   localparam int IDX_W      = 8;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 24;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [CSR_AW-1:0] {
      CSR_CELL_UNDER,
      CSR_CELL_OVER,
      CSR_IMBALANCE,
      CSR_DISAGREE,
      CSR_PACK_MAX,
      CSR_PACK_MIN,
      CSR_SOC_HIGH,
      CSR_SOC_LOW
   } csr_index_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_under_mv;
      logic [CELL_W-1:0] cell_over_mv;
      logic [CELL_W-1:0] imbalance_mv;
      logic [PACK_W-1:0] disagree_mv;
      logic [PACK_W-1:0] pack_max_mv;
      logic [PACK_W-1:0] pack_min_mv;
      logic [SOC_W-1:0]  soc_high;
      logic [SOC_W-1:0]  soc_low;
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      cell_under_mv: 16'd2500,
      cell_over_mv:  16'd4200,
      imbalance_mv:  16'd200,
      disagree_mv:   24'd2000,
      pack_max_mv:   24'hFF_FFFF,
      pack_min_mv:   24'd0,
      soc_high:      10'd1000,
      soc_low:       10'd0
   };

   typedef struct packed {
      logic [CELL_W-1:0] cell_mv;
      logic              last_cell;
      logic [PACK_W-1:0] pack_mv;
      logic [SOC_W-1:0]  charge_permille;
   } item_type;

   typedef struct packed {
      logic [IDX_W-1:0] cell_number;
      logic             cell_under;
      logic             cell_over;
      logic             pass_end;
      logic             imbalanced;
      logic [IDX_W-1:0] lowest_cell;
      logic [IDX_W-1:0] highest_cell;
      logic             sum_disagrees;
      logic             pack_over;
      logic             pack_under;
      logic             over_charged;
      logic             over_discharged;
   } result_type;

endpackage

@@ rtl/cvfm_csr.sv @@
// ----------------------------------------------------------------------------
// Cell voltage fault monitor threshold registers
// Write-only register file holding the cell, pack and charge limits.
// ----------------------------------------------------------------------------
module cvfm_csr import cvfm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_CELL_UNDER: cfg_in.cell_under_mv = csr_wdata[CELL_W-1:0];
            CSR_CELL_OVER:  cfg_in.cell_over_mv  = csr_wdata[CELL_W-1:0];
            CSR_IMBALANCE:  cfg_in.imbalance_mv  = csr_wdata[CELL_W-1:0];
            CSR_DISAGREE:   cfg_in.disagree_mv   = csr_wdata[PACK_W-1:0];
            CSR_PACK_MAX:   cfg_in.pack_max_mv   = csr_wdata[PACK_W-1:0];
            CSR_PACK_MIN:   cfg_in.pack_min_mv   = csr_wdata[PACK_W-1:0];
            CSR_SOC_HIGH:   cfg_in.soc_high      = csr_wdata[SOC_W-1:0];
            CSR_SOC_LOW:    cfg_in.soc_low       = csr_wdata[SOC_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/cvfm_eval.sv @@
// ----------------------------------------------------------------------------
// Cell voltage fault monitor evaluation stage
// Input register, pass state (index, sum, min, max) and the flag logic.
// ----------------------------------------------------------------------------
module cvfm_eval import cvfm_pkg::*; #(
   parameter int MAX_CELLS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   item,
   input  cfg_type    cfg,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type result
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CELLS - 1);

   logic              s1_valid_ff, s1_valid_in;
   item_type          item_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [PACK_W-1:0] sum_ff, sum_in;
   logic [CELL_W-1:0] min_ff, min_in, max_ff, max_in;
   logic [IDX_W-1:0]  min_idx_ff, min_idx_in, max_idx_ff, max_idx_in;

   logic              load, advance;
   logic [PACK_W:0]   sum_wide;
   logic [PACK_W-1:0] sum_sat, diff;
   logic [CELL_W-1:0] min_v, max_v;
   logic [IDX_W-1:0]  min_i, max_i;
   logic              under;

   assign in_ready = !s1_valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign advance  = s1_valid_ff && out_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      sum_wide = {1'b0, sum_ff} + (PACK_W + 1)'(item_ff.cell_mv);
      sum_sat  = sum_wide[PACK_W] ? '1 : sum_wide[PACK_W-1:0];
      min_v    = min_ff;
      min_i    = min_idx_ff;
      if (item_ff.cell_mv < min_ff) begin
         min_v = item_ff.cell_mv;
         min_i = idx_ff;
      end
      max_v    = max_ff;
      max_i    = max_idx_ff;
      if (item_ff.cell_mv > max_ff) begin
         max_v = item_ff.cell_mv;
         max_i = idx_ff;
      end
      diff  = (sum_sat >= item_ff.pack_mv) ? sum_sat - item_ff.pack_mv
                                           : item_ff.pack_mv - sum_sat;
      under = item_ff.cell_mv < cfg.cell_under_mv;
   end

   always_comb begin
      result             = '0;
      result.cell_number = idx_ff;
      result.cell_under  = under;
      result.cell_over   = !under && (item_ff.cell_mv > cfg.cell_over_mv);
      if (item_ff.last_cell) begin
         result.pass_end        = 1'b1;
         result.imbalanced      = (max_v >= min_v) && ((max_v - min_v) > cfg.imbalance_mv);
         result.lowest_cell     = min_i;
         result.highest_cell    = max_i;
         result.sum_disagrees   = diff > cfg.disagree_mv;
         result.pack_over       = item_ff.pack_mv > cfg.pack_max_mv;
         result.pack_under      = !result.pack_over && (item_ff.pack_mv < cfg.pack_min_mv);
         result.over_charged    = item_ff.charge_permille > cfg.soc_high;
         result.over_discharged = !result.over_charged &&
                                  (item_ff.charge_permille < cfg.soc_low);
      end
   end

   // pass state moves on when the beat leaves for the result register
   always_comb begin
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      min_idx_in = min_idx_ff;
      max_idx_in = max_idx_ff;
      if (advance) begin
         if (item_ff.last_cell) begin
            idx_in     = '0;
            sum_in     = '0;
            min_in     = '1;
            max_in     = '0;
            min_idx_in = '0;
            max_idx_in = '0;
         end else begin
            idx_in     = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
            sum_in     = sum_sat;
            min_in     = min_v;
            max_in     = max_v;
            min_idx_in = min_i;
            max_idx_in = max_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         idx_ff      <= '0;
         sum_ff      <= '0;
         min_ff      <= '1;
         max_ff      <= '0;
         min_idx_ff  <= '0;
         max_idx_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         idx_ff      <= idx_in;
         sum_ff      <= sum_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         min_idx_ff  <= min_idx_in;
         max_idx_ff  <= max_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign out_valid = s1_valid_ff;

endmodule

@@ rtl/cvfm_rsp_reg.sv @@
// ----------------------------------------------------------------------------
// Cell voltage fault monitor result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module cvfm_rsp_reg import cvfm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_result,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       valid_ff, valid_in;
   result_type result_ff;
   logic       load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= in_result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

@@ rtl/cell_voltage_fault_monitor.sv @@
// ----------------------------------------------------------------------------
// Cell voltage fault monitor
// Per-cell window check, pass min/max/sum tracking and end-of-pass pack flags.
//
//   channel  dir  handshake        contents
//   req      in   tvalid/tready    one cell beat, tlast on final cell
//   rsp      out  tvalid/tready    one result beat per cell, tlast on pass end
//   csr      in   we               threshold register write, no read-back
//
// One beat per cycle unless rsp stalls; req to rsp via input and result regs.
// Ready passes straight back through the input and result registers, no bubble.
// Synchronous reset restores default thresholds and clears the pass state.
// A stalled rsp holds its beat; req takes one more beat, then stalls too.
// ----------------------------------------------------------------------------
module cell_voltage_fault_monitor import cvfm_pkg::*; #(
   parameter int MAX_CELLS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cell_mv[15:0], pack_mv[39:16], charge_permille[49:40], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cell_number[7:0], cell_under[8], cell_over[9], imbalanced[10],
   // lowest_cell[18:11], highest_cell[26:19], sum_disagrees[27],
   // pack_over[28], pack_under[29], over_charged[30], over_discharged[31]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_AW-1:0]     csr_addr,
   input  logic [CSR_DW-1:0]     csr_wdata
);

   cfg_type    cfg;
   item_type   item;
   result_type eval_result, rsp_result;
   logic       eval_valid, eval_ready;

   assign item.cell_mv         = req_tdata[CELL_W-1:0];
   assign item.last_cell       = req_tlast;
   assign item.pack_mv         = req_tdata[CELL_W+PACK_W-1:CELL_W];
   assign item.charge_permille = req_tdata[CELL_W+PACK_W+SOC_W-1:CELL_W+PACK_W];

   cvfm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cvfm_eval #(
      .MAX_CELLS (MAX_CELLS)
   ) u_eval (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .item      (item),
      .cfg       (cfg),
      .out_valid (eval_valid),
      .out_ready (eval_ready),
      .result    (eval_result)
   );

   cvfm_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (eval_valid),
      .in_ready   (eval_ready),
      .in_result  (eval_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   assign rsp_tdata = {rsp_result.over_discharged, rsp_result.over_charged,
                       rsp_result.pack_under, rsp_result.pack_over,
                       rsp_result.sum_disagrees, rsp_result.highest_cell,
                       rsp_result.lowest_cell, rsp_result.imbalanced,
                       rsp_result.cell_over, rsp_result.cell_under,
                       rsp_result.cell_number};
   assign rsp_tlast = rsp_result.pass_end;

endmodule

@@ rtl/cvfm_checker.sv @@
// ----------------------------------------------------------------------------
// Cell voltage fault monitor port checker
// Concurrent checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "cell_voltage_fault_monitor_assert.svh"

module cvfm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   `CVFM_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_tvalid, "rsp valid after reset")

   `CVFM_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp beat changed under stall")

   // pass flags only on the final cell
   `CVFM_ASSERT_SAME(a_mid_pass_clear, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[31:10] == 22'd0, "pass flags set mid pass")

   // each window reports at most one side
   `CVFM_ASSERT_SAME(a_window_excl, clock, reset, rsp_tvalid, !(rsp_tdata[8] && rsp_tdata[9]) && !(rsp_tdata[28] && rsp_tdata[29]) && !(rsp_tdata[30] && rsp_tdata[31]), "both sides of a window flagged")

endmodule

bind cell_voltage_fault_monitor cvfm_checker u_cvfm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
